// ===== design/pcap_pkg.sv =====
package pcap_pkg;

   // parser phases
   typedef enum logic [1:0] {
      PH_GLOBAL = 2'd0,
      PH_RECORD = 2'd1,
      PH_PACKET = 2'd2
   } phase_type;

   // result kinds
   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_TOTALS = 1'b1;

   // register reset value, ARP
   localparam logic [15:0] ETYPE_RESET = 16'h0806;
   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

   // byte offsets inside the record header and the packet
   localparam logic [31:0] CAPLEN_FIRST_POS = 32'd8;
   localparam logic [31:0] CAPLEN_LAST_POS = 32'd11;
   localparam logic [31:0] SRC_MAC_POS = 32'd6;
   localparam logic [31:0] ETYPE_POS = 32'd12;
   localparam logic [31:0] ETYPE_LO_POS = 32'd13;
   localparam logic [31:0] OPCODE_POS = 32'd20;
   localparam logic [31:0] OPCODE_LO_POS = 32'd21;

   // result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // one result beat
   typedef struct packed {
      logic        result_kind;
      logic [31:0] packet_number;
      logic [31:0] matched_count;
      logic [47:0] destination_mac;
      logic [47:0] source_mac;
      logic        is_request;
   } rsp_item_type;

endpackage

// ===== design/pcap_arp_packet_classifier.sv =====
// one byte accepted per cycle while req_full is low; the parser updates counters per byte
// a report or totals beat is queued by the byte that ends it; rsp_ shows the queue head
// a four-beat result queue lets bytes keep flowing while results wait to be popped
// req_full is high whenever that queue holds four beats, even with rsp_pop high
// synchronous active-high reset: parser back to the global header, counts cleared,
// result queue emptied, match register back to 0x0806
module pcap_arp_packet_classifier #(
   parameter int GLOBAL_HEADER_BYTES = 24,
   parameter int RECORD_HEADER_BYTES = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_packet_number,
   output logic [31:0] rsp_matched_count,
   output logic [47:0] rsp_destination_mac,
   output logic [47:0] rsp_source_mac,
   output logic        rsp_is_request,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import pcap_pkg::*;

   logic         in_accept;
   logic         item_valid;
   rsp_item_type item;
   rsp_item_type head;

   assign in_accept = req_push && !req_full;

   // front end: parse and classify each byte
   pcap_parse #(
      .GLOBAL_HEADER_BYTES (GLOBAL_HEADER_BYTES),
      .RECORD_HEADER_BYTES (RECORD_HEADER_BYTES),
      .COUNT_WIDTH         (COUNT_WIDTH)
   ) u_parse (
      .clock              (clock),
      .reset              (reset),
      .in_valid_i         (in_accept),
      .data_byte_i        (req_data_byte),
      .end_of_input_i     (req_end_of_input),
      .csr_write_enable_i (csr_write_enable),
      .csr_write_data_i   (csr_write_data),
      .item_valid_o       (item_valid),
      .item_o             (item)
   );

   // back end: result queue toward the consumer
   pcap_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (item_valid),
      .push_item_i (item),
      .full_o      (req_full),
      .pop_i       (rsp_pop),
      .empty_o     (rsp_empty),
      .head_o      (head)
   );

   assign rsp_result_kind     = head.result_kind;
   assign rsp_packet_number   = head.packet_number;
   assign rsp_matched_count   = head.matched_count;
   assign rsp_destination_mac = head.destination_mac;
   assign rsp_source_mac      = head.source_mac;
   assign rsp_is_request      = head.is_request;

endmodule

// ===== design/pcap_parse.sv =====
module pcap_parse #(
   parameter int GLOBAL_HEADER_BYTES = 24,
   parameter int RECORD_HEADER_BYTES = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid_i,
   input  logic [7:0]            data_byte_i,
   input  logic                  end_of_input_i,
   input  logic                  csr_write_enable_i,
   input  logic [15:0]           csr_write_data_i,
   output logic                  item_valid_o,
   output pcap_pkg::rsp_item_type item_o
);
   import pcap_pkg::*;

   localparam logic [31:0] GLOBAL_LAST = 32'(GLOBAL_HEADER_BYTES - 1);
   localparam logic [31:0] RECORD_LAST = 32'(RECORD_HEADER_BYTES - 1);

   phase_type              phase_ff, phase_in;
   logic [31:0]            pos_ff, pos_in;
   logic [31:0]            caplen_ff, caplen_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH-1:0] matched_ff, matched_in;
   logic [47:0]            dmac_ff, dmac_in;
   logic [47:0]            smac_ff, smac_in;
   logic [15:0]            etype_ff, etype_in;
   logic [15:0]            opcode_ff, opcode_in;
   logic [15:0]            match_ff;
   logic                   finish;
   logic [5:0]             dmac_lsb;
   logic [3:0]             smac_slot;
   logic [5:0]             smac_lsb;

   // byte slots inside the mac words, first byte most significant
   assign dmac_lsb  = {3'd5 - pos_ff[2:0], 3'b000};
   assign smac_slot = 4'd11 - pos_ff[3:0];
   assign smac_lsb  = {smac_slot[2:0], 3'b000};

   // match register
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= ETYPE_RESET;
      end else if (csr_write_enable_i) begin
         match_ff <= csr_write_data_i;
      end
   end

   // next state and result
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      caplen_in    = caplen_ff;
      total_in     = total_ff;
      matched_in   = matched_ff;
      dmac_in      = dmac_ff;
      smac_in      = smac_ff;
      etype_in     = etype_ff;
      opcode_in    = opcode_ff;
      finish       = 1'b0;
      item_valid_o = 1'b0;
      item_o       = '0;
      if (in_valid_i) begin
         if (end_of_input_i) begin
            // totals only while a record header is awaited
            if (phase_ff == PH_RECORD) begin
               item_valid_o         = 1'b1;
               item_o.result_kind   = KIND_TOTALS;
               item_o.packet_number = 32'(total_ff);
               item_o.matched_count = 32'(matched_ff);
            end
            phase_in   = PH_GLOBAL;
            pos_in     = '0;
            caplen_in  = '0;
            total_in   = '0;
            matched_in = '0;
            dmac_in    = '0;
            smac_in    = '0;
            etype_in   = '0;
            opcode_in  = '0;
         end else begin
            case (phase_ff)
               PH_RECORD: begin
                  if (pos_ff >= CAPLEN_FIRST_POS && pos_ff <= CAPLEN_LAST_POS) begin
                     caplen_in[{pos_ff[1:0], 3'b000} +: 8] = data_byte_i;
                  end
                  if (pos_ff == RECORD_LAST) begin
                     dmac_in   = '0;
                     smac_in   = '0;
                     etype_in  = '0;
                     opcode_in = '0;
                     pos_in    = '0;
                     phase_in  = PH_PACKET;
                     if (caplen_in == 32'd0) begin
                        finish = 1'b1;
                     end
                  end else begin
                     pos_in = pos_ff + 32'd1;
                  end
               end
               PH_PACKET: begin
                  // capture the header fields
                  if (pos_ff < SRC_MAC_POS) begin
                     dmac_in[dmac_lsb +: 8] = data_byte_i;
                  end else if (pos_ff < ETYPE_POS) begin
                     smac_in[smac_lsb +: 8] = data_byte_i;
                  end else if (pos_ff == ETYPE_POS) begin
                     etype_in[15:8] = data_byte_i;
                  end else if (pos_ff == ETYPE_LO_POS) begin
                     etype_in[7:0] = data_byte_i;
                  end else if (pos_ff == OPCODE_POS) begin
                     opcode_in[15:8] = data_byte_i;
                  end else if (pos_ff == OPCODE_LO_POS) begin
                     opcode_in[7:0] = data_byte_i;
                  end
                  if (pos_ff + 32'd1 == caplen_ff) begin
                     finish = 1'b1;
                  end else begin
                     pos_in = pos_ff + 32'd1;
                  end
               end
               default: begin
                  // global header, and the unused phase code
                  if (pos_ff == GLOBAL_LAST) begin
                     phase_in  = PH_RECORD;
                     pos_in    = '0;
                     caplen_in = '0;
                  end else begin
                     phase_in = PH_GLOBAL;
                     pos_in   = pos_ff + 32'd1;
                  end
               end
            endcase
            // end of packet: count and report a match
            if (finish) begin
               total_in  = total_ff + 1'b1;
               phase_in  = PH_RECORD;
               pos_in    = '0;
               caplen_in = '0;
               if (etype_in == match_ff) begin
                  matched_in             = matched_ff + 1'b1;
                  item_valid_o           = 1'b1;
                  item_o.result_kind     = KIND_PACKET;
                  item_o.packet_number   = 32'(total_in);
                  item_o.matched_count   = 32'(matched_in);
                  item_o.destination_mac = dmac_in;
                  item_o.source_mac      = smac_in;
                  item_o.is_request      = (opcode_in == OPCODE_REQUEST);
               end
            end
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_GLOBAL;
         pos_ff     <= '0;
         caplen_ff  <= '0;
         total_ff   <= '0;
         matched_ff <= '0;
         dmac_ff    <= '0;
         smac_ff    <= '0;
         etype_ff   <= '0;
         opcode_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         caplen_ff  <= caplen_in;
         total_ff   <= total_in;
         matched_ff <= matched_in;
         dmac_ff    <= dmac_in;
         smac_ff    <= smac_in;
         etype_ff   <= etype_in;
         opcode_ff  <= opcode_in;
      end
   end

   // end of input restarts the parser with cleared counts
   a_eoi_restart: assert property (@(posedge clock) disable iff (reset)
      in_valid_i && end_of_input_i |=> phase_ff == PH_GLOBAL && pos_ff == 32'd0
                                       && total_ff == '0 && matched_ff == '0)
      else $error("parser not cleared after end of input");

   // a result beat only comes from an accepted byte
   a_item_from_input: assert property (@(posedge clock) disable iff (reset)
      item_valid_o |-> in_valid_i)
      else $error("result without accepted input");

   // every packet report bumps the matched count by one
   a_report_counts: assert property (@(posedge clock) disable iff (reset)
      item_valid_o && item_o.result_kind == KIND_PACKET
      |=> matched_ff == COUNT_WIDTH'($past(matched_ff) + 1'b1))
      else $error("matched count out of step with reports");

endmodule

// ===== design/pcap_rsp_queue.sv =====
module pcap_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_i,
   input  pcap_pkg::rsp_item_type push_item_i,
   output logic                  full_o,
   input  logic                  pop_i,
   output logic                  empty_o,
   output pcap_pkg::rsp_item_type head_o
);
   import pcap_pkg::*;

   rsp_item_type           slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full_o  = (count_ff == RSP_CNT_W'(RSP_DEPTH));
   assign empty_o = (count_ff == '0);
   assign head_o  = slot_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item_i;
      end
   end

   // the front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("push into full result queue");

   // a lone pop drops the fill count by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop_i && !empty_o && !push_i |=> count_ff == RSP_CNT_W'($past(count_ff) - 1'b1))
      else $error("fill count wrong after pop");

   // pointers stay apart by the fill count while the queue is not full
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      !full_o |-> RSP_PTR_W'(wr_ptr_ff - rd_ptr_ff) == RSP_PTR_W'(count_ff))
      else $error("queue pointers out of step");

endmodule
